@@ design/gwm_pkg.sv @@
// Shared constants, types and character helpers for the glob wildcard matcher.
package gwm_pkg;

    // Pattern storage: four 64-bit registers of eight characters each.
    localparam int PAT_LIMIT = 32;
    localparam int POS_NUM   = PAT_LIMIT + 1;
    localparam int LEN_W     = 6;
    localparam int CHAR_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PAT_WORDS = 4;

    localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_QMARK = 8'h3F;

    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_BODY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_A   = 3'd0,
        REG_PAT_B   = 3'd1,
        REG_PAT_C   = 3'd2,
        REG_PAT_D   = 3'd3,
        REG_PAT_LEN = 3'd4,
        REG_MODE    = 3'd5
    } t_cfg_reg;

    // Per-transaction control shared by every cell of the row.
    typedef struct packed {
        logic fresh;      // first character of a value: start from the initial set
        logic gate_init;  // re-seed the initial set before consuming the character
        logic load;       // store the advanced positions
        logic gate_next;  // re-seed the initial set after consuming the character
    } t_cell_ctrl;

    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic is_word(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || (c == 8'h5F);
    endfunction

endpackage

@@ design/gwm_in_if.sv @@
// Text character channel: valid/ready handshake with one character per transaction.
interface gwm_in_if;
    logic                        valid;
    logic                        ready;
    logic [gwm_pkg::CHAR_W-1:0]  text_char;
    logic                        char_present;
    logic                        last_char;

    modport source (output valid, text_char, char_present, last_char, input ready);
    modport sink   (input valid, text_char, char_present, last_char, output ready);
endinterface

@@ design/gwm_out_if.sv @@
// Match result channel: valid/ready handshake with one verdict per transaction.
interface gwm_out_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, matched, input ready);
    modport sink   (input valid, matched, output ready);
endinterface

@@ design/gwm_cell.sv @@
// One pattern position of the automaton row: holds its active bit and feeds its neighbour.
module gwm_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [gwm_pkg::CHAR_W-1:0]  i_pat_char,
    input  logic                        i_en,
    input  logic                        i_init,
    input  logic                        i_closed,
    input  logic                        i_adv_in,
    input  logic [gwm_pkg::CHAR_W-1:0]  i_text_fold,
    input  gwm_pkg::t_cell_ctrl         i_ctrl,
    output logic                        o_act,
    output logic                        o_prop,
    output logic                        o_nxt,
    output logic                        o_adv_out
);

    logic r_act;
    logic n_act;
    logic a1;
    logic is_star;
    logic is_qmark;
    logic lit_hit;

    always_comb begin
        is_star  = (i_pat_char == gwm_pkg::CHAR_STAR);
        is_qmark = (i_pat_char == gwm_pkg::CHAR_QMARK);
        lit_hit  = (gwm_pkg::fold(i_pat_char) == i_text_fold);
        a1       = (i_ctrl.fresh ? i_init : r_act) | (i_ctrl.gate_init & i_init);
        // A star keeps its own position alive; anything else hands the token on.
        o_adv_out = i_en & a1 & ~is_star & (is_qmark | lit_hit);
        o_nxt     = (i_en & a1 & is_star) | i_adv_in;
        o_prop    = i_en & is_star;
        o_act     = a1;
        n_act     = i_closed | (i_ctrl.gate_next & i_init);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (i_ctrl.load) begin
            r_act <= n_act;
        end
    end

endmodule

@@ design/gwm_closure.sv @@
// Star closure across the row: a run of stars passes an active bit straight through.
module gwm_closure (
    input  logic [gwm_pkg::POS_NUM-1:0] i_act,
    input  logic [gwm_pkg::POS_NUM-1:0] i_prop,
    output logic [gwm_pkg::POS_NUM-1:0] o_closed
);

    logic [gwm_pkg::POS_NUM-1:0] seed;
    logic [gwm_pkg::POS_NUM:0]   sum;
    logic [gwm_pkg::POS_NUM-1:0] carries;

    // The carries of seed + prop mark every position reached through a run of stars.
    always_comb begin
        seed     = i_act & i_prop;
        sum      = {1'b0, seed} + {1'b0, i_prop};
        carries  = sum[gwm_pkg::POS_NUM-1:0] ^ seed ^ i_prop;
        o_closed = i_act | carries;
    end

endmodule

@@ design/glob_wildcard_matcher_core.sv @@
// Top level of the glob wildcard matcher: configuration, cell row and result queue.
//
//  channel     | dir | handshake            | payload
//  ------------+-----+----------------------+-----------------------------------------
//  i_text_ch   | in  | valid / ready        | text_char[7:0], char_present, last_char
//  o_match_ch  | out | valid / ready        | matched
//  i_cfg_*     | in  | write enable only    | i_cfg_idx[2:0], i_cfg_data[63:0]
//
// One character transaction is taken every cycle while the queue has room; the verdict
// enters the output queue on the cycle after the transaction that carries last_char.
// The cycle time is set by the 33-position star closure carry chain after the cell row.
// Reset is synchronous and clears the configuration and the automaton state.
// The two-entry result queue lets input continue while a verdict waits; input stalls
// only when both entries are held.
module glob_wildcard_matcher_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    gwm_in_if.sink                          i_text_ch,
    gwm_out_if.source                       o_match_ch,
    input  logic                            i_cfg_we,
    input  logic [gwm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gwm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int NP = gwm_pkg::POS_NUM;
    localparam int NC = gwm_pkg::PAT_LIMIT;
    localparam int LW = gwm_pkg::LEN_W;
    localparam int CW = gwm_pkg::CHAR_W;

    // Configuration registers.
    logic [gwm_pkg::PAT_WORDS-1:0][gwm_pkg::CFG_DATA_W-1:0] r_pat;
    logic [LW-1:0] r_len;
    logic          r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_len  <= '0;
            r_mode <= gwm_pkg::MODE_KEY;
        end else if (i_cfg_we) begin
            unique case (gwm_pkg::t_cfg_reg'(i_cfg_idx))
                gwm_pkg::REG_PAT_A:   r_pat[0] <= i_cfg_data;
                gwm_pkg::REG_PAT_B:   r_pat[1] <= i_cfg_data;
                gwm_pkg::REG_PAT_C:   r_pat[2] <= i_cfg_data;
                gwm_pkg::REG_PAT_D:   r_pat[3] <= i_cfg_data;
                gwm_pkg::REG_PAT_LEN: r_len    <= i_cfg_data[LW-1:0];
                gwm_pkg::REG_MODE:    r_mode   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Pattern decode.
    logic [NC-1:0][CW-1:0] pat_byte;
    logic [LW-1:0]         total;
    logic [LW-1:0]         total_m1;
    logic [LW-1:0]         len;
    logic                  special;
    logic                  strip;
    logic                  full;
    logic                  bounded;

    always_comb begin
        for (int k = 0; k < NC; k++) begin
            pat_byte[k] = r_pat[k / 8][(k % 8) * CW +: CW];
        end
        total    = (r_len > LW'(NC)) ? LW'(NC) : r_len;
        total_m1 = total - LW'(1);
        special  = 1'b0;
        for (int k = 0; k < NC; k++) begin
            if ((LW'(k) < total) && ((pat_byte[k] == gwm_pkg::CHAR_STAR) ||
                                     (pat_byte[k] == gwm_pkg::CHAR_QMARK))) begin
                special = 1'b1;
            end
        end
        strip = (r_mode == gwm_pkg::MODE_BODY) && (total != '0) &&
                (pat_byte[0] == gwm_pkg::CHAR_STAR) &&
                (pat_byte[total_m1[4:0]] == gwm_pkg::CHAR_STAR);
        full    = (r_mode == gwm_pkg::MODE_KEY) && special;
        bounded = (r_mode == gwm_pkg::MODE_BODY) && !strip;
        if (strip) begin
            len = (total >= LW'(2)) ? total - LW'(2) : '0;
        end else begin
            len = total;
        end
    end

    // Automaton state outside the row.
    logic r_prev_bnd;
    logic r_found;
    logic r_nonempty;

    logic in_acc;
    logic step;
    logic present;
    logic last;
    logic nonword;
    logic [CW-1:0] text_fold;
    gwm_pkg::t_cell_ctrl ctrl;

    logic [NP-1:0] act_v;
    logic [NP-1:0] prop_v;
    logic [NP-1:0] nxt_v;
    logic [NP-1:0] adv_v;
    logic [NP-1:0] closed_v;
    logic [NP-1:0] init_v;
    logic [NP-1:0] en_v;
    logic [NP-1:0][CW-1:0] cell_char;

    always_comb begin
        for (int j = 0; j < NP; j++) begin
            en_v[j] = (LW'(j) < len);
            if (j < NC - 1) begin
                cell_char[j] = strip ? pat_byte[j + 1] : pat_byte[j];
            end else if (j < NC) begin
                cell_char[j] = strip ? pat_byte[0] : pat_byte[j];
            end else begin
                cell_char[j] = '0;
            end
        end
    end

    assign present   = i_text_ch.char_present;
    assign last      = i_text_ch.last_char;
    assign nonword   = !gwm_pkg::is_word(i_text_ch.text_char);
    assign text_fold = gwm_pkg::fold(i_text_ch.text_char);
    assign in_acc    = i_text_ch.valid && i_text_ch.ready;
    assign step      = in_acc && (present || last);

    always_comb begin
        ctrl.fresh     = !r_nonempty;
        ctrl.gate_init = !full && (!bounded || r_prev_bnd);
        ctrl.load      = in_acc && present && !last;
        ctrl.gate_next = !full && (!bounded || nonword);
    end

    for (genvar j = 0; j < NP; j++) begin : g_row
        gwm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_pat_char  (cell_char[j]),
            .i_en        (en_v[j]),
            .i_init      (init_v[j]),
            .i_closed    (closed_v[j]),
            .i_adv_in    ((j == 0) ? 1'b0 : adv_v[(j == 0) ? 0 : j - 1]),
            .i_text_fold (text_fold),
            .i_ctrl      (ctrl),
            .o_act       (act_v[j]),
            .o_prop      (prop_v[j]),
            .o_nxt       (nxt_v[j]),
            .o_adv_out   (adv_v[j])
        );
    end

    // Initial set: position zero and every position reached from it through stars.
    gwm_closure u_init_closure (
        .i_act    (NP'(1)),
        .i_prop   (prop_v),
        .o_closed (init_v)
    );

    gwm_closure u_step_closure (
        .i_act    (nxt_v),
        .i_prop   (prop_v),
        .o_closed (closed_v)
    );

    logic pend_before;
    logic pend_after;
    logic found_char;
    logic verdict;
    logic [NP-1:0] after_v;

    always_comb begin
        pend_before = act_v[len];
        after_v     = closed_v | (ctrl.gate_next ? init_v : '0);
        pend_after  = after_v[len];
        found_char  = r_found;
        if (present && !full && pend_before && (!bounded || nonword)) begin
            found_char = 1'b1;
        end
        verdict = (r_nonempty || present) &&
                  (found_char || (present ? pend_after : pend_before));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_bnd <= 1'b1;
            r_found    <= 1'b0;
            r_nonempty <= 1'b0;
        end else if (step) begin
            if (last) begin
                r_prev_bnd <= 1'b1;
                r_found    <= 1'b0;
                r_nonempty <= 1'b0;
            end else begin
                r_prev_bnd <= nonword;
                r_found    <= found_char;
                r_nonempty <= 1'b1;
            end
        end
    end

    // Two-entry result queue.
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       r_q0;
    logic       r_q1;
    logic       n_q0;
    logic       n_q1;
    logic       push;
    logic       pop;

    assign push = in_acc && last;
    assign pop  = o_match_ch.valid && o_match_ch.ready;

    always_comb begin
        n_cnt = r_cnt;
        n_q0  = r_q0;
        n_q1  = r_q1;
        priority if (push && pop) begin
            if (r_cnt == 2'd1) begin
                n_q0 = verdict;
            end else begin
                n_q0 = r_q1;
                n_q1 = verdict;
            end
        end else if (pop) begin
            n_q0  = r_q1;
            n_cnt = r_cnt - 2'd1;
        end else if (push) begin
            if (r_cnt == 2'd0) begin
                n_q0 = verdict;
            end else begin
                n_q1 = verdict;
            end
            n_cnt = r_cnt + 2'd1;
        end else begin
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign i_text_ch.ready   = (r_cnt != 2'd2);
    assign o_match_ch.valid  = (r_cnt != 2'd0);
    assign o_match_ch.matched = r_q0;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && last) |=> o_match_ch.valid)
        else $error("no verdict queued after the final character");

    a_last_clears_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && last) |=> (!r_nonempty && !r_found && r_prev_bnd))
        else $error("value state not cleared after the final character");

    a_found_needs_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> r_nonempty)
        else $error("match recorded for a value with no characters");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_acc && last) |=> (r_cnt <= $past(r_cnt)))
        else $error("verdict queued without a final character");
`endif

endmodule

@@ tb/glob_wildcard_matcher_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the glob wildcard matcher: directed table, then random values.
module glob_wildcard_matcher_core_tb;
    import gwm_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gwm_in_if  text_ch();
    gwm_out_if match_ch();

    glob_wildcard_matcher_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_text_ch  (text_ch),
        .o_match_ch (match_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // One row of the directed table: either a full pattern setting or one character.
    typedef struct packed {
        bit           setup;
        logic [255:0] pat_bits;
        logic [5:0]   pat_len;
        logic         mode;
        logic [7:0]   ch;
        logic         present;
        logic         last;
        bit           typed;
        bit           want;
    } stim_row_t;

    stim_row_t stim_rows[$];

    // Our own copy of the configuration and of the automaton state.
    logic [63:0] pat_word [PAT_WORDS];
    logic [5:0]  pat_len_reg;
    logic        mode_reg;
    logic [32:0] live_pos;
    bit          at_boundary;
    bit          end_reached;
    bit          hit_seen;
    bit          saw_char;

    bit          verdict_q[$];
    logic [7:0]  value_bytes[$];
    int unsigned err_count;
    int unsigned items_sent;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned recv_hold;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        err_count++;
    endtask

    function automatic logic [7:0] pat_at(input int unsigned j);
        return pat_word[j / 8][(j % 8) * 8 +: 8];
    endfunction

    function automatic logic [7:0] lower_case(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A]}) ? (c | 8'h20) : c;
    endfunction

    function automatic bit word_byte(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F};
    endfunction

    // A live star position also makes the position after it live.
    function automatic logic [32:0] star_fill(input logic [32:0] act, input int unsigned off,
                                              input int unsigned len);
        for (int unsigned j = 0; j < len; j++) begin
            if (act[j] && pat_at(off + j) == CHAR_STAR) begin
                act[j + 1] = 1'b1;
            end
        end
        return act;
    endfunction

    function automatic logic [32:0] step_char(input logic [32:0] act, input int unsigned off,
                                              input int unsigned len, input logic [7:0] c);
        logic [32:0] nxt;
        logic [7:0]  p;
        nxt = '0;
        for (int unsigned j = 0; j < len; j++) begin
            if (act[j]) begin
                p = pat_at(off + j);
                if (p == CHAR_STAR) begin
                    nxt[j] = 1'b1;
                end else if (p == CHAR_QMARK || lower_case(p) == lower_case(c)) begin
                    nxt[j + 1] = 1'b1;
                end
            end
        end
        return star_fill(nxt, off, len);
    endfunction

    function automatic void clear_value_state();
        live_pos    = 33'd1;
        at_boundary = 1'b1;
        end_reached = 1'b0;
        hit_seen    = 1'b0;
        saw_char    = 1'b0;
    endfunction

    // Advances the automaton by one transaction; returns 1 when a verdict is due.
    function automatic bit predict_verdict(input logic [7:0] c, input bit present,
                                           input bit last, output bit verdict);
        int unsigned total;
        int unsigned off;
        int unsigned len;
        bit          wild;
        bit          whole;
        bit          bounded;
        bit          nonword;
        logic [32:0] keep;
        logic [32:0] seed;
        verdict = 1'b0;
        total = (pat_len_reg > PAT_LIMIT) ? PAT_LIMIT : pat_len_reg;
        wild = 1'b0;
        for (int unsigned j = 0; j < total; j++) begin
            if (pat_at(j) == CHAR_STAR || pat_at(j) == CHAR_QMARK) begin
                wild = 1'b1;
            end
        end
        off = 0;
        len = total;
        whole = 1'b0;
        bounded = 1'b0;
        if (mode_reg == MODE_KEY) begin
            whole = wild;
        end else if (total >= 1 && pat_at(0) == CHAR_STAR && pat_at(total - 1) == CHAR_STAR) begin
            // Outer stars are dropped and the rest is searched anywhere.
            off = 1;
            len = (total >= 2) ? total - 2 : 0;
        end else begin
            bounded = 1'b1;
        end
        if (!present && !last) begin
            return 1'b0;
        end
        keep = '0;
        for (int unsigned j = 0; j <= len; j++) begin
            keep[j] = 1'b1;
        end
        seed = star_fill(33'd1, off, len);
        live_pos = star_fill(live_pos & keep, off, len);
        if (!whole && (!bounded || at_boundary)) begin
            live_pos |= seed;
        end
        end_reached = live_pos[len];
        if (present) begin
            nonword = !word_byte(c);
            if (!whole && end_reached && (!bounded || nonword)) begin
                hit_seen = 1'b1;
            end
            live_pos = step_char(live_pos, off, len, c);
            at_boundary = nonword;
            saw_char = 1'b1;
            if (!whole && (!bounded || at_boundary)) begin
                live_pos |= seed;
            end
            end_reached = live_pos[len];
        end
        if (!last) begin
            return 1'b0;
        end
        if (end_reached) begin
            hit_seen = 1'b1;
        end
        verdict = saw_char && hit_seen;
        clear_value_state();
        return 1'b1;
    endfunction

    function automatic void add_setup(input string s, input logic [7:0] fill,
                                      input logic [5:0] n, input logic m);
        stim_row_t row;
        row = '0;
        row.setup = 1'b1;
        row.pat_bits = {32{fill}};
        for (int i = 0; i < s.len(); i++) begin
            row.pat_bits[i * 8 +: 8] = s[i];
        end
        row.pat_len = n;
        row.mode = m;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_item(input logic [7:0] c, input bit p, input bit l,
                                     input bit typed, input bit want);
        stim_row_t row;
        row = '0;
        row.ch = c;
        row.present = p;
        row.last = l;
        row.typed = typed;
        row.want = want;
        stim_rows.push_back(row);
    endfunction

    task automatic send_item(input logic [7:0] c, input bit present, input bit last,
                             input bit typed, input bit want);
        int unsigned gap;
        bit          verdict;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        text_ch.valid        <= 1'b1;
        text_ch.text_char    <= c;
        text_ch.char_present <= present;
        text_ch.last_char    <= last;
        @(posedge i_clk);
        while (text_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        if (present || last) begin
            items_sent++;
        end
        if (predict_verdict(c, present, last, verdict)) begin
            verdict_q.push_back(typed ? want : verdict);
        end
    endtask

    task automatic wait_drained();
        text_ch.valid <= 1'b0;
        while (verdict_q.size() != 0) begin
            @(posedge i_clk);
        end
        // The verdict of the last transaction may still be on its way into the queue.
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_PAT_A:   pat_word[0] = data;
            REG_PAT_B:   pat_word[1] = data;
            REG_PAT_C:   pat_word[2] = data;
            REG_PAT_D:   pat_word[3] = data;
            REG_PAT_LEN: pat_len_reg = data[LEN_W-1:0];
            REG_MODE:    mode_reg = data[0];
            default: ;
        endcase
    endtask

    task automatic load_setting(input logic [255:0] bits, input logic [5:0] n, input logic m);
        wait_drained();
        write_reg(REG_PAT_A, bits[63:0]);
        write_reg(REG_PAT_B, bits[127:64]);
        write_reg(REG_PAT_C, bits[191:128]);
        write_reg(REG_PAT_D, bits[255:192]);
        write_reg(REG_PAT_LEN, {58'd0, n});
        write_reg(REG_MODE, {63'd0, m});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_pat_char();
        case ($urandom_range(9))
            0, 1:    return CHAR_STAR;
            2:       return CHAR_QMARK;
            3:       return "a";
            4:       return "B";
            5:       return "c";
            6:       return " ";
            7:       return "_";
            8:       return ".";
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] text_byte();
        case ($urandom_range(11))
            0:       return "a";
            1:       return "A";
            2:       return "b";
            3:       return "B";
            4:       return "c";
            5:       return "C";
            6:       return " ";
            7:       return "_";
            8:       return ".";
            9:       return "0";
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_setting();
        logic [255:0] bits;
        logic [5:0]   n;
        logic         m;
        int unsigned  r;
        int unsigned  used;
        for (int i = 0; i < 8; i++) begin
            bits[i * 32 +: 32] = $urandom;
        end
        // Mostly short patterns; now and then up to the full store, or beyond it.
        r = $urandom_range(19);
        if (r < 16) begin
            n = $urandom_range(6);
        end else if (r < 19) begin
            n = $urandom_range(32, 7);
        end else begin
            n = $urandom_range(63, 33);
        end
        used = (n > PAT_LIMIT) ? PAT_LIMIT : n;
        for (int unsigned j = 0; j < used; j++) begin
            if ($urandom_range(4) != 0) begin
                bits[j * 8 +: 8] = pick_pat_char();
            end
        end
        m = $urandom_range(1);
        if (m == MODE_BODY && used >= 1 && $urandom_range(2) == 0) begin
            bits[7:0] = CHAR_STAR;
            bits[(used - 1) * 8 +: 8] = CHAR_STAR;
        end
        load_setting(bits, n, m);
    endtask

    // Most values are built from the pattern itself so that matches are common.
    task automatic make_value();
        int unsigned kind;
        int unsigned used;
        logic [7:0]  p;
        value_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 60) begin
            repeat ($urandom_range(2)) value_bytes.push_back(text_byte());
            used = (pat_len_reg > PAT_LIMIT) ? PAT_LIMIT : pat_len_reg;
            for (int unsigned j = 0; j < used; j++) begin
                p = pat_at(j);
                if (p == CHAR_STAR) begin
                    repeat ($urandom_range(3)) value_bytes.push_back(text_byte());
                end else if (p == CHAR_QMARK || $urandom_range(9) == 0) begin
                    value_bytes.push_back(text_byte());
                end else if ((p | 8'h20) inside {[8'h61:8'h7A]} && $urandom_range(1)) begin
                    value_bytes.push_back(p ^ 8'h20);
                end else begin
                    value_bytes.push_back(p);
                end
            end
            repeat ($urandom_range(2)) value_bytes.push_back(text_byte());
        end else if (kind < 85) begin
            repeat ($urandom_range(8)) value_bytes.push_back(text_byte());
        end else begin
            repeat ($urandom_range(6, 1)) value_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic send_value();
        bit          marker;
        int unsigned n;
        n = value_bytes.size();
        marker = (n == 0) || ($urandom_range(9) == 0);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) begin
                send_item(8'($urandom), 1'b0, 1'b0, 1'b0, 1'b0);
            end
            send_item(value_bytes[i], 1'b1, !marker && i == n - 1, 1'b0, 1'b0);
        end
        if (marker) begin
            send_item(8'($urandom), 1'b0, 1'b1, 1'b0, 1'b0);
        end
    endtask

    task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                             input int unsigned target);
        int unsigned goal;
        int unsigned setting_goal;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        goal = items_sent + target;
        while (items_sent < goal) begin
            random_setting();
            setting_goal = items_sent + $urandom_range(60, 20);
            while (items_sent < setting_goal) begin
                make_value();
                send_value();
            end
        end
    endtask

    // Result side: checks every verdict transaction and stalls as the phase asks.
    initial begin
        bit want;
        match_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && match_ch.valid === 1'b1 && match_ch.ready === 1'b1) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("verdict arrived with none expected");
                end else begin
                    want = verdict_q.pop_front();
                    if (match_ch.matched !== want) begin
                        report_mismatch($sformatf("matched %b, expected %b",
                                                  match_ch.matched, want));
                    end
                end
            end
            if (recv_hold > 0) begin
                match_ch.ready <= 1'b0;
                recv_hold--;
            end else begin
                match_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        int unsigned drain;
        text_ch.valid        <= 1'b0;
        text_ch.text_char    <= '0;
        text_ch.char_present <= 1'b0;
        text_ch.last_char    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_PAT_A;
        i_cfg_data <= '0;
        i_rst_n    <= 1'b0;
        err_count = 0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 0;
        for (int i = 0; i < PAT_WORDS; i++) begin
            pat_word[i] = '0;
        end
        pat_len_reg = '0;
        mode_reg = MODE_KEY;
        clear_value_state();

        // Straight out of reset the empty pattern matches any non-empty value.
        add_item("a", 1'b1, 1'b1, 1'b1, 1'b1);
        add_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        add_item(8'hFF, 1'b0, 1'b1, 1'b1, 1'b0);
        add_item("Z", 1'b1, 1'b1, 1'b1, 1'b1);
        add_setup("a?C*", 8'h00, 6'd4, MODE_KEY);
        add_item("A", 1'b1, 1'b0, 1'b0, 1'b0);
        add_item("B", 1'b1, 1'b0, 1'b0, 1'b0);
        add_item("c", 1'b1, 1'b0, 1'b0, 1'b0);
        add_item(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0);
        add_setup("*xy*", 8'h00, 6'd4, MODE_BODY);
        add_item("X", 1'b1, 1'b0, 1'b0, 1'b0);
        add_item("y", 1'b1, 1'b1, 1'b0, 1'b0);
        add_setup("*", 8'h00, 6'd1, MODE_BODY);
        add_item("0", 1'b1, 1'b1, 1'b0, 1'b0);
        add_setup("ab", 8'h00, 6'd2, MODE_BODY);
        add_item("-", 1'b1, 1'b0, 1'b0, 1'b0);
        add_item("a", 1'b1, 1'b0, 1'b0, 1'b0);
        add_item("B", 1'b1, 1'b1, 1'b0, 1'b0);
        add_item("a", 1'b1, 1'b0, 1'b0, 1'b0);
        add_item("b", 1'b1, 1'b0, 1'b0, 1'b0);
        add_item("_", 1'b1, 1'b1, 1'b0, 1'b0);
        add_setup("", 8'h00, 6'd0, MODE_BODY);
        add_item("-", 1'b1, 1'b1, 1'b0, 1'b0);
        add_item("a", 1'b1, 1'b1, 1'b0, 1'b0);
        // An over-long length is cut to the full store of pattern characters.
        add_setup("", CHAR_STAR, 6'd63, MODE_KEY);
        add_item(8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
        add_setup("", 8'hFF, 6'd63, MODE_KEY);
        add_item(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0);
        // A new pattern loaded part-way through a value applies from the next character.
        add_setup("xy", 8'h00, 6'd2, MODE_KEY);
        add_item("x", 1'b1, 1'b0, 1'b0, 1'b0);
        add_setup("x?", 8'h00, 6'd2, MODE_KEY);
        add_item("q", 1'b1, 1'b1, 1'b0, 1'b0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[r]) begin
            if (stim_rows[r].setup) begin
                load_setting(stim_rows[r].pat_bits, stim_rows[r].pat_len, stim_rows[r].mode);
            end else begin
                send_item(stim_rows[r].ch, stim_rows[r].present, stim_rows[r].last,
                          stim_rows[r].typed, stim_rows[r].want);
            end
        end

        run_phase(0, 0, 270);
        // Hold the result side off so that the result queue fills and input backs up.
        recv_hold = 300;
        repeat (40) send_item(8'($urandom), 1'b1, 1'b1, 1'b0, 1'b0);
        wait_drained();
        run_phase(77, 0, 270);
        run_phase(0, 77, 270);
        run_phase(12, 12, 270);

        text_ch.valid <= 1'b0;
        drain = 0;
        while (verdict_q.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected verdicts never arrived", verdict_q.size()));
        end
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
